// ===== rtl/mstk_pkg.sv =====
package mstk_pkg;

   localparam int VC_BITS          = 7;
   localparam int VERTEX_BITS      = 6;
   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 256;
   localparam int DEF_WEIGHT_BITS  = 16;
   localparam logic [VC_BITS-1:0] VC_RESET = 7'd64;

   typedef struct packed {
      logic load_take;
      logic pass_init;
      logic scan_init;
      logic scan_step;
      logic skip_best;
      logic find_src;
      logic find_dest;
      logic find_step;
      logic link;
      logic emit_init;
      logic emit_load;
      logic emit_next;
      logic graph_clear;
   } mstk_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic best_found;
      logic best_in_range;
      logic at_root;
      logic tree_full;
      logic emit_last;
   } mstk_status_type;

endpackage

// ===== rtl/mstk_ram.sv =====
module mstk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/mstk_datapath.sv =====
module mstk_datapath #(
   parameter int MAX_VERTICES = mstk_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = mstk_pkg::DEF_MAX_EDGES,
   parameter int WEIGHT_BITS  = mstk_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mstk_pkg::VC_BITS-1:0]        csr_wr_data,
   input  logic [mstk_pkg::VERTEX_BITS-1:0]    req_edge_src,
   input  logic [mstk_pkg::VERTEX_BITS-1:0]    req_edge_dest,
   input  logic signed [WEIGHT_BITS-1:0]       req_edge_weight,
   input  mstk_pkg::mstk_cmd_type              cmd,
   output mstk_pkg::mstk_status_type           status,
   output logic                                rsp_valid,
   output logic [mstk_pkg::VERTEX_BITS-1:0]    rsp_tree_src,
   output logic [mstk_pkg::VERTEX_BITS-1:0]    rsp_tree_dest,
   output logic signed [WEIGHT_BITS-1:0]       rsp_tree_weight,
   output logic                                rsp_edge_valid,
   output logic                                rsp_spanning,
   output logic                                rsp_edges_dropped,
   output logic                                rsp_last_result
);

   localparam int VB  = mstk_pkg::VERTEX_BITS;
   localparam int VCB = mstk_pkg::VC_BITS;
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int PAW = $clog2(MAX_VERTICES);
   localparam int EW  = 2 * VB + WEIGHT_BITS;

   logic [VCB-1:0] vc_ff, vc_in, n_eff;
   logic [ECW-1:0] count_ff, count_in, scan_addr_ff, scan_addr_in;
   logic           dropped_ff, dropped_in;
   logic [PAW-1:0] selected_ff, selected_in;
   logic [MAX_VERTICES-1:0] valid_ff, valid_in;
   logic           have_prev_ff, have_prev_in, have_best_ff, have_best_in;
   logic signed [WEIGHT_BITS-1:0] prev_w_ff, prev_w_in, best_w_ff, best_w_in;
   logic [EAW-1:0] prev_idx_ff, prev_idx_in, best_idx_ff, best_idx_in;
   logic [EAW-1:0] eval_idx_ff, eval_idx_in;
   logic           eval_vld_ff, eval_vld_in;
   logic [VB-1:0]  best_src_ff, best_src_in, best_dest_ff, best_dest_in;
   logic [PAW-1:0] v_ff, v_in, rs_ff, rs_in, emit_ff, emit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0]  out_src_ff, out_src_in, out_dest_ff, out_dest_in;
   logic signed [WEIGHT_BITS-1:0] out_w_ff, out_w_in;
   logic           out_ev_ff, out_ev_in, out_sp_ff, out_sp_in;
   logic           out_dr_ff, out_dr_in, out_last_ff, out_last_in;

   logic           in_ok, store_full, store_we, link_we;
   logic [EW-1:0]  edge_q, res_q;
   logic [PAW-1:0] par_q, par_eff;
   logic [VB-1:0]  e_src;
   logic [VB-1:0]  e_dest;
   logic signed [WEIGHT_BITS-1:0] e_w;
   logic           gt_prev, lt_best, roots_differ;

   always_comb begin
      if (vc_ff < VCB'(2)) begin
         n_eff = VCB'(2);
      end else if (vc_ff > VCB'(MAX_VERTICES)) begin
         n_eff = VCB'(MAX_VERTICES);
      end else begin
         n_eff = vc_ff;
      end
   end

   assign in_ok = ({1'b0, req_edge_src} < n_eff) && ({1'b0, req_edge_dest} < n_eff);
   assign store_full = (count_ff == ECW'(MAX_EDGES));
   assign store_we = cmd.load_take && in_ok && !store_full;

   assign e_src  = edge_q[EW-1 -: VB];
   assign e_dest = edge_q[EW-VB-1 -: VB];
   assign e_w    = signed'(edge_q[WEIGHT_BITS-1:0]);

   assign gt_prev = !have_prev_ff || (e_w > prev_w_ff) ||
                    ((e_w == prev_w_ff) && (eval_idx_ff > prev_idx_ff));
   assign lt_best = !have_best_ff || (e_w < best_w_ff);

   assign par_eff = valid_ff[v_ff] ? par_q : v_ff;
   assign roots_differ = (rs_ff != v_ff);
   assign link_we = cmd.link && roots_differ;

   mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (count_ff[EAW-1:0]),
      .wr_data ({req_edge_src, req_edge_dest, req_edge_weight}),
      .rd_addr (scan_addr_ff[EAW-1:0]),
      .rd_data (edge_q)
   );

   mstk_ram #(.WIDTH(PAW), .DEPTH(MAX_VERTICES)) u_parent_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (rs_ff),
      .wr_data (v_ff),
      .rd_addr (v_ff),
      .rd_data (par_q)
   );

   mstk_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_result_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (selected_ff),
      .wr_data ({best_src_ff, best_dest_ff, best_w_ff}),
      .rd_addr (emit_ff),
      .rd_data (res_q)
   );

   always_comb begin
      vc_in        = csr_wr_en ? csr_wr_data : vc_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      selected_in  = selected_ff;
      valid_in     = valid_ff;
      have_prev_in = have_prev_ff;
      prev_w_in    = prev_w_ff;
      prev_idx_in  = prev_idx_ff;
      have_best_in = have_best_ff;
      best_w_in    = best_w_ff;
      best_idx_in  = best_idx_ff;
      best_src_in  = best_src_ff;
      best_dest_in = best_dest_ff;
      scan_addr_in = scan_addr_ff;
      eval_vld_in  = eval_vld_ff;
      eval_idx_in  = eval_idx_ff;
      v_in         = v_ff;
      rs_in        = rs_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      out_src_in   = out_src_ff;
      out_dest_in  = out_dest_ff;
      out_w_in     = out_w_ff;
      out_ev_in    = out_ev_ff;
      out_sp_in    = out_sp_ff;
      out_dr_in    = out_dr_ff;
      out_last_in  = out_last_ff;

      if (cmd.load_take) begin
         if (store_we) begin
            count_in = count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.pass_init) begin
         valid_in     = '0;
         selected_in  = '0;
         have_prev_in = 1'b0;
      end
      if (cmd.scan_init) begin
         scan_addr_in = '0;
         eval_vld_in  = 1'b0;
         have_best_in = 1'b0;
      end
      if (cmd.scan_step) begin
         eval_vld_in = (scan_addr_ff < count_ff);
         eval_idx_in = scan_addr_ff[EAW-1:0];
         if (scan_addr_ff < count_ff) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         if (eval_vld_ff && gt_prev && lt_best) begin
            have_best_in = 1'b1;
            best_w_in    = e_w;
            best_idx_in  = eval_idx_ff;
            best_src_in  = e_src;
            best_dest_in = e_dest;
         end
      end
      if (cmd.skip_best || cmd.link) begin
         have_prev_in = 1'b1;
         prev_w_in    = best_w_ff;
         prev_idx_in  = best_idx_ff;
      end
      if (cmd.skip_best) begin
         dropped_in = 1'b1;
      end
      if (cmd.find_src) begin
         v_in = best_src_ff[PAW-1:0];
      end
      if (cmd.find_dest) begin
         rs_in = v_ff;
         v_in  = best_dest_ff[PAW-1:0];
      end
      if (cmd.find_step) begin
         v_in = par_eff;
      end
      if (link_we) begin
         valid_in[rs_ff] = 1'b1;
         selected_in     = selected_ff + 1'b1;
      end
      if (cmd.emit_init) begin
         emit_in = '0;
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         out_ev_in    = (selected_ff != '0);
         out_src_in   = out_ev_in ? res_q[EW-1 -: VB] : '0;
         out_dest_in  = out_ev_in ? res_q[EW-VB-1 -: VB] : '0;
         out_w_in     = out_ev_in ? signed'(res_q[WEIGHT_BITS-1:0]) : '0;
         out_sp_in    = status.tree_full;
         out_dr_in    = dropped_ff;
         out_last_in  = status.emit_last;
      end
      if (cmd.emit_next) begin
         rsp_valid_in = 1'b0;
         emit_in      = emit_ff + 1'b1;
      end
      if (cmd.graph_clear) begin
         count_in    = '0;
         selected_in = '0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= mstk_pkg::VC_RESET;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         selected_ff  <= '0;
         valid_ff     <= '0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
         eval_vld_ff  <= 1'b0;
         scan_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vc_ff        <= vc_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         selected_ff  <= selected_in;
         valid_ff     <= valid_in;
         have_prev_ff <= have_prev_in;
         have_best_ff <= have_best_in;
         eval_vld_ff  <= eval_vld_in;
         scan_addr_ff <= scan_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_w_ff    <= prev_w_in;
      prev_idx_ff  <= prev_idx_in;
      best_w_ff    <= best_w_in;
      best_idx_ff  <= best_idx_in;
      best_src_ff  <= best_src_in;
      best_dest_ff <= best_dest_in;
      eval_idx_ff  <= eval_idx_in;
      v_ff         <= v_in;
      rs_ff        <= rs_in;
      emit_ff      <= emit_in;
      out_src_ff   <= out_src_in;
      out_dest_ff  <= out_dest_in;
      out_w_ff     <= out_w_in;
      out_ev_ff    <= out_ev_in;
      out_sp_ff    <= out_sp_in;
      out_dr_ff    <= out_dr_in;
      out_last_ff  <= out_last_in;
   end

   assign status.scan_done     = !(scan_addr_ff < count_ff) && !eval_vld_ff;
   assign status.best_found    = have_best_ff;
   assign status.best_in_range = ({1'b0, best_src_ff} < n_eff) &&
                                 ({1'b0, best_dest_ff} < n_eff);
   assign status.at_root       = (par_eff == v_ff);
   assign status.tree_full     = (VCB'(selected_ff) == n_eff - 1'b1);
   assign status.emit_last     = (selected_ff == '0) || (emit_ff == selected_ff - 1'b1);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tree_src      = out_src_ff;
   assign rsp_tree_dest     = out_dest_ff;
   assign rsp_tree_weight   = out_w_ff;
   assign rsp_edge_valid    = out_ev_ff;
   assign rsp_spanning      = out_sp_ff;
   assign rsp_edges_dropped = out_dr_ff;
   assign rsp_last_result   = out_last_ff;

   // only a root is ever linked under another root
   assert property (@(posedge clock) disable iff (reset)
      link_we |-> !valid_ff[rs_ff])
      else $error("linked vertex is not a root");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ECW'(MAX_EDGES))
      else $error("edge count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      link_we |-> !status.tree_full)
      else $error("edge linked after tree complete");

endmodule

// ===== rtl/mstk_ctrl.sv =====
module mstk_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last_edge,
   output logic                      req_ready,
   input  logic                      rsp_ready,
   input  mstk_pkg::mstk_status_type status,
   output mstk_pkg::mstk_cmd_type    cmd
);

   localparam logic [3:0] ST_LOAD      = 4'd0;
   localparam logic [3:0] ST_SCAN_INIT = 4'd1;
   localparam logic [3:0] ST_SCAN      = 4'd2;
   localparam logic [3:0] ST_FS_RD     = 4'd3;
   localparam logic [3:0] ST_FS_CHK    = 4'd4;
   localparam logic [3:0] ST_FD_RD     = 4'd5;
   localparam logic [3:0] ST_FD_CHK    = 4'd6;
   localparam logic [3:0] ST_EMIT_RD   = 4'd7;
   localparam logic [3:0] ST_EMIT_LD   = 4'd8;
   localparam logic [3:0] ST_EMIT_WAIT = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load_take = 1'b1;
               if (req_last_edge) begin
                  cmd.pass_init = 1'b1;
                  state_in      = ST_SCAN_INIT;
               end
            end
         end
         ST_SCAN_INIT: begin
            if (status.tree_full) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.scan_done) begin
               cmd.scan_step = 1'b1;
            end else if (!status.best_found) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end else if (!status.best_in_range) begin
               cmd.skip_best = 1'b1;
               state_in      = ST_SCAN_INIT;
            end else begin
               cmd.find_src = 1'b1;
               state_in     = ST_FS_RD;
            end
         end
         ST_FS_RD: state_in = ST_FS_CHK;
         ST_FS_CHK: begin
            if (status.at_root) begin
               cmd.find_dest = 1'b1;
               state_in      = ST_FD_RD;
            end else begin
               cmd.find_step = 1'b1;
               state_in      = ST_FS_RD;
            end
         end
         ST_FD_RD: state_in = ST_FD_CHK;
         ST_FD_CHK: begin
            if (status.at_root) begin
               cmd.link = 1'b1;
               state_in = ST_SCAN_INIT;
            end else begin
               cmd.find_step = 1'b1;
               state_in      = ST_FD_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.emit_last) begin
                  cmd.graph_clear = 1'b1;
                  state_in        = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);

   assert property (@(posedge clock) disable iff (reset)
      cmd.link |-> $past(state_ff) == ST_FD_RD)
      else $error("link without a fresh parent read");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_WAIT) |-> $past(state_ff) == ST_EMIT_LD ||
                                     $past(state_ff) == ST_EMIT_WAIT)
      else $error("result wait without a loaded word");

   assert property (@(posedge clock) disable iff (reset)
      cmd.graph_clear |=> req_ready)
      else $error("not back to loading after the run");

endmodule

// ===== rtl/minimum_spanning_tree_kruskal.sv =====
// Kruskal minimum spanning tree.
// req channel: one edge word per cycle (src, dest, signed weight, last flag).
// Words are taken one per cycle while loading; the word with last_edge set
// closes the graph and req_ready stays low until every result is taken.
// Edges beyond MAX_EDGES or with an endpoint >= vertex_count (taken as 2..MAX_VERTICES) are dropped.
// The pass then picks edges in ascending weight (ties by arrival order):
// each pick is one scan of the edge memory over the E stored edges,
// followed by a root walk (read, then check, per vertex) from each endpoint.
// rsp channel: one word per selected edge, or a single word with
// edge_valid low if none; each word is read, loaded into the output
// register and held there until rsp_ready. spanning and edges_dropped
// are the same on every word; last_result marks the final one.
// csr_wr_data sets vertex_count (reset 64); the user must write it only
// while loading, as the block itself does not enforce this.
// Reset (synchronous) empties the graph and returns to loading.
module minimum_spanning_tree_kruskal #(
   parameter int MAX_VERTICES = mstk_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = mstk_pkg::DEF_MAX_EDGES,
   parameter int WEIGHT_BITS  = mstk_pkg::DEF_WEIGHT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mstk_pkg::VC_BITS-1:0]      csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mstk_pkg::VERTEX_BITS-1:0]  req_edge_src,
   input  logic [mstk_pkg::VERTEX_BITS-1:0]  req_edge_dest,
   input  logic signed [WEIGHT_BITS-1:0]     req_edge_weight,
   input  logic                              req_last_edge,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mstk_pkg::VERTEX_BITS-1:0]  rsp_tree_src,
   output logic [mstk_pkg::VERTEX_BITS-1:0]  rsp_tree_dest,
   output logic signed [WEIGHT_BITS-1:0]     rsp_tree_weight,
   output logic                              rsp_edge_valid,
   output logic                              rsp_spanning,
   output logic                              rsp_edges_dropped,
   output logic                              rsp_last_result
);

   mstk_pkg::mstk_cmd_type    cmd;
   mstk_pkg::mstk_status_type status;

   mstk_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_edge (req_last_edge),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   mstk_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_edge_src      (req_edge_src),
      .req_edge_dest     (req_edge_dest),
      .req_edge_weight   (req_edge_weight),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_tree_src      (rsp_tree_src),
      .rsp_tree_dest     (rsp_tree_dest),
      .rsp_tree_weight   (rsp_tree_weight),
      .rsp_edge_valid    (rsp_edge_valid),
      .rsp_spanning      (rsp_spanning),
      .rsp_edges_dropped (rsp_edges_dropped),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
